// ===== design/dmc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared types, constants and the month length table for the day and minute
// to calendar converter.
// ----------------------------------------------------------------------------
package dmc_pkg;

  localparam logic [11:0] BaseYear    = 12'd1980;
  localparam logic [5:0]  MinsPerHour = 6'd60;
  localparam logic [2:0]  WeekLen     = 3'd7;
  localparam logic [8:0]  YearLenStd  = 9'd365;
  localparam logic [8:0]  YearLenLeap = 9'd366;

  localparam logic [3:0] MonthJan = 4'd1;
  localparam logic [3:0] MonthFeb = 4'd2;
  localparam logic [3:0] MonthApr = 4'd4;
  localparam logic [3:0] MonthJun = 4'd6;
  localparam logic [3:0] MonthSep = 4'd9;
  localparam logic [3:0] MonthNov = 4'd11;
  localparam logic [3:0] MonthDec = 4'd12;

  typedef struct packed {
    logic [14:0] day_count;
    logic [10:0] minute_count;
  } dmc_in_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [2:0]  weekday;
    logic [5:0]  hour;
    logic [5:0]  minute;
  } dmc_out_t;

  typedef struct packed {
    logic load;
    logic year_en;
    logic month_en;
    logic min_en;
  } dmc_cmd_t;

  typedef struct packed {
    logic year_done;
    logic month_done;
    logic min_done;
  } dmc_sts_t;

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StYear  = 4'b0010,
    StMonth = 4'b0100,
    StOut   = 4'b1000
  } dmc_state_e;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month) inside
      MonthFeb:                               len = leap ? 5'd29 : 5'd28;
      MonthApr, MonthJun, MonthSep, MonthNov: len = 5'd30;
      default:                                len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

// ===== design/days_minutes_to_calendar.sv =====
`timescale 1ns / 1ps
// The day count spans at most 89 whole years, at most 11 whole months pass in
// the final year, and the hour is at most 34. The minute loop runs beside the
// year and month loops. One item at a time: busy is low again the cycle after
// done_o. Reset is asynchronous and returns the sequencer to idle; the done_o
// strobe marks the result for one cycle only.
// ----------------------------------------------------------------------------
// days_minutes_to_calendar
// Converts a day count since 1980-01-01 and a minute count into calendar
// date, weekday, hour and minute.
// ----------------------------------------------------------------------------
module days_minutes_to_calendar
  import dmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  dmc_in_t  item_i,
  output logic     done_o,
  output dmc_out_t result_o
);

  dmc_cmd_t cmd;
  dmc_sts_t sts;

  dmc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (done_o)
  );

  dmc_datapath u_datapath (
    .clk_i   (clk_i),
    .cmd_i   (cmd),
    .item_i  (item_i),
    .sts_o   (sts),
    .result_o(result_o)
  );

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.month >= MonthJan) && (result_o.month <= MonthDec))
    else $error("month out of range in result");

  a_minute_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.minute < MinsPerHour))
    else $error("minute not reduced below one hour");

  a_day_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.day_of_month != 5'd0))
    else $error("day of month is zero");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o && !busy)
    else $error("more than one result for an item");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy && !done_o)
    else $error("accepted item did not start work");

endmodule

// ===== design/dmc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ctrl
// Sequencer: loads an item, runs the year loop, then the month loop while the
// minute loop finishes, and raises done_o with the result for one cycle.
// ----------------------------------------------------------------------------
module dmc_ctrl
  import dmc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dmc_sts_t sts_i,
  output dmc_cmd_t cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  dmc_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = StYear;
        end
      end
      StYear: begin
        cmd_o.year_en = 1'b1;
        cmd_o.min_en  = 1'b1;
        if (sts_i.year_done) begin
          state_d = StMonth;
        end
      end
      StMonth: begin
        cmd_o.month_en = 1'b1;
        cmd_o.min_en   = 1'b1;
        if (sts_i.month_done && sts_i.min_done) begin
          state_d = StOut;
        end
      end
      StOut: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = (state_q == StOut);

endmodule

// ===== design/dmc_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_datapath
// Working registers with one subtract-and-compare step each for the year,
// month and minute loops, plus the weekday residue taken at load.
// ----------------------------------------------------------------------------
module dmc_datapath
  import dmc_pkg::*;
(
  input  logic     clk_i,
  input  dmc_cmd_t cmd_i,
  input  dmc_in_t  item_i,
  output dmc_sts_t sts_o,
  output dmc_out_t result_o
);

  logic [14:0] days_q;
  logic [6:0]  yoff_q;
  logic [3:0]  month_q;
  logic [10:0] mins_q;
  logic [5:0]  hour_q;
  logic [2:0]  wday_q;

  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  mlen;
  logic [15:0] day_inc;
  logic [5:0]  dig_sum;
  logic [3:0]  fold;
  logic [2:0]  wday_d;

  // Years stay within 1980 to 2069. The only century year there is 2000,
  // which is a leap year, so every fourth year from 1980 is leap.
  assign leap = (yoff_q[1:0] == 2'd0);
  assign ylen = leap ? YearLenLeap : YearLenStd;
  assign mlen = month_len(month_q, leap);

  assign sts_o.year_done  = (days_q < {6'd0, ylen});
  assign sts_o.month_done = (month_q == MonthDec) || (days_q < {10'd0, mlen});
  assign sts_o.min_done   = (mins_q < {5'd0, MinsPerHour});

  // Since 8 is 1 modulo 7, the sum of the octal digits keeps the residue.
  always_comb begin
    day_inc = {1'b0, item_i.day_count} + 16'd1;
    dig_sum = '0;
    for (int i = 0; i < 6; i++) begin
      dig_sum = dig_sum + {3'd0, 3'({2'b00, day_inc} >> (3 * i))};
    end
    fold = {1'b0, dig_sum[5:3]} + {1'b0, dig_sum[2:0]};
    if (fold >= {1'b0, WeekLen}) begin
      wday_d = 3'(fold - {1'b0, WeekLen}) + 3'd1;
    end else begin
      wday_d = fold[2:0] + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      days_q  <= item_i.day_count;
      yoff_q  <= '0;
      month_q <= MonthJan;
      mins_q  <= item_i.minute_count;
      hour_q  <= '0;
      wday_q  <= wday_d;
    end else begin
      if (cmd_i.year_en && !sts_o.year_done) begin
        days_q <= days_q - {6'd0, ylen};
        yoff_q <= yoff_q + 7'd1;
      end
      if (cmd_i.month_en && !sts_o.month_done) begin
        days_q  <= days_q - {10'd0, mlen};
        month_q <= month_q + 4'd1;
      end
      if (cmd_i.min_en && !sts_o.min_done) begin
        mins_q <= mins_q - {5'd0, MinsPerHour};
        hour_q <= hour_q + 6'd1;
      end
    end
  end

  assign result_o.year         = BaseYear + {5'd0, yoff_q};
  assign result_o.month        = month_q;
  assign result_o.day_of_month = days_q[4:0] + 5'd1;
  assign result_o.weekday      = wday_q;
  assign result_o.hour         = hour_q;
  assign result_o.minute       = mins_q[5:0];

endmodule

// ===== sim/days_minutes_to_calendar_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// days_minutes_to_calendar_tb
// Sends day and minute stamps to the calendar converter. Each accepted stamp
// is converted to a date and time by a model in the bench. Each done_o strobe
// is compared field by field against the oldest pending date.
// ----------------------------------------------------------------------------
module days_minutes_to_calendar_tb;
  import dmc_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainWait  = 110;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  dmc_in_t  item_i;
  logic     done_o;
  dmc_out_t result_o;

  dmc_out_t    pending_dates[$];
  dmc_out_t    want_date;
  int unsigned idle_pct;
  int unsigned items_sent;
  int unsigned dates_checked;
  int unsigned mismatches;
  int unsigned cycle_cnt;

  days_minutes_to_calendar dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic bit is_leap(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
  endfunction

  // Calendar date and time of one stamp, by year and then month subtraction.
  function automatic dmc_out_t calendar_of(input dmc_in_t stamp);
    int unsigned left;
    int unsigned yr;
    int unsigned mo;
    int unsigned mlen;
    bit          leap;
    dmc_out_t    date;
    left = stamp.day_count;
    yr   = BaseYear;
    while (left >= (is_leap(yr) ? YearLenLeap : YearLenStd)) begin
      left -= is_leap(yr) ? YearLenLeap : YearLenStd;
      yr++;
    end
    left++;
    leap = is_leap(yr);
    mo   = MonthJan;
    while (mo < MonthDec) begin
      case (mo)
        MonthFeb:                               mlen = leap ? 29 : 28;
        MonthApr, MonthJun, MonthSep, MonthNov: mlen = 30;
        default:                                mlen = 31;
      endcase
      if (left <= mlen) break;
      left -= mlen;
      mo++;
    end
    date.year         = yr[11:0];
    date.month        = mo[3:0];
    date.day_of_month = left[4:0];
    date.weekday      = 3'(((stamp.day_count + 1) % WeekLen) + 1);
    date.hour         = 6'(stamp.minute_count / MinsPerHour);
    date.minute       = 6'(stamp.minute_count % MinsPerHour);
    return date;
  endfunction

  function automatic void report_field(input string field, input int unsigned want,
                                       input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endfunction

  // Holds start high until the item is taken. Start is not lowered between
  // back-to-back items, so it never gets two updates in one step.
  task automatic send_item(input logic [14:0] days, input logic [10:0] mins);
    dmc_in_t     stamp;
    int unsigned gap;
    stamp.day_count    = days;
    stamp.minute_count = mins;
    gap = (idle_pct != 0 && $urandom_range(9) == 0) ? $urandom_range(DrainWait) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= stamp;
    do @(posedge clk_i); while (busy);
    pending_dates.push_back(calendar_of(stamp));
    items_sent++;
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_range_extremes();
    send_item(15'd0, 11'd0);
    send_item(15'h7FFF, 11'h7FF);
    send_item(15'd0, 11'h7FF);
    send_item(15'h7FFF, 11'd0);
  endtask

  // Leap days in 1980 and 2000 (a century year that is a leap year) and
  // the turns of the year around them.
  task automatic test_leap_years();
    send_item(15'd58, 11'd720);
    send_item(15'd59, 11'd721);
    send_item(15'd60, 11'd722);
    send_item(15'd365, 11'd1439);
    send_item(15'd366, 11'd1);
    send_item(15'd424, 11'd300);
    send_item(15'd425, 11'd301);
    send_item(15'd7364, 11'd600);
    send_item(15'd7670, 11'd1000);
    send_item(15'd7671, 11'd1001);
  endtask

  task automatic test_weekdays();
    for (int d = 1; d < 7; d++) send_item(15'(d), 11'(d * 97));
  endtask

  // Minute counts at the hour turn and past a full day, where the hour
  // is allowed to exceed 23.
  task automatic test_minute_wrap();
    send_item(15'd100, 11'd59);
    send_item(15'd100, 11'd60);
    send_item(15'd100, 11'd1439);
    send_item(15'd100, 11'd1440);
  endtask

  task automatic send_random_stamps(input int unsigned count);
    logic [14:0] days;
    logic [10:0] mins;
    int unsigned pick;
    repeat (count) begin
      // Some stamps stay in the first few years to keep the latency short.
      days = ($urandom_range(4) == 0) ? 15'($urandom_range(1500)) : 15'($urandom_range(32767));
      pick = $urandom_range(99);
      if (pick < 60)      mins = 11'($urandom_range(1439));
      else if (pick < 85) mins = 11'($urandom_range(2047));
      else                mins = 11'($urandom_range(2047, 1440));
      send_item(days, mins);
    end
  endtask

  task automatic test_random_stamps();
    idle_pct = 38;
    send_random_stamps(450);
    idle_pct = 0;
    send_random_stamps(300);
    idle_pct = 38;
    wait_until_drained();
    send_random_stamps(580);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected date, expected none, actual %p", $time, result_o);
        mismatches++;
      end else begin
        want_date = pending_dates.pop_front();
        report_field("year", want_date.year, result_o.year);
        report_field("month", want_date.month, result_o.month);
        report_field("day_of_month", want_date.day_of_month, result_o.day_of_month);
        report_field("weekday", want_date.weekday, result_o.weekday);
        report_field("hour", want_date.hour, result_o.hour);
        report_field("minute", want_date.minute, result_o.minute);
        dates_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, CycleLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    start         = 1'b0;
    item_i        = '0;
    idle_pct      = 38;
    items_sent    = 0;
    dates_checked = 0;
    mismatches    = 0;
    cycle_cnt     = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_range_extremes();
    test_leap_years();
    test_weekdays();
    test_minute_wrap();
    test_random_stamps();

    wait_until_drained();
    repeat (DrainWait) @(posedge clk_i);
    if (pending_dates.size() != 0) begin
      $display("%0t: %0d dates never arrived", $time, pending_dates.size());
      mismatches++;
    end

    $display("Sent %0d stamps and checked %0d dates, %0d mismatches.",
             items_sent, dates_checked, mismatches);
    $display("Covered field extremes, leap days, all weekdays, hours past 23, random stamps.");
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
